### src/gwm_pkg.sv
`timescale 1ns / 1ps

package gwm_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_NAME   = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  localparam logic [7:0] SYM_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] SYM_ANY_RUN = 8'h2A;  // '*'

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic       restart;  // back to only position zero active
    logic       append;   // write sym at the cell whose index equals the length
    logic       step;     // advance activity by one name byte
    logic [7:0] sym;
  } cell_ctrl_t;

endpackage

### src/gwm_closure.sv
`timescale 1ns / 1ps

// Star closure over the activity bits: activity runs right across every
// consecutive '*'. Done as one carry chain: generate = star & act,
// propagate = star & ~act, so the adder's carries are the bits reached.
module gwm_closure #(
  parameter int N = 32
) (
  input  logic [N:0]   act,
  input  logic [N-1:0] star,
  output logic [N:0]   closed
);

  logic [N:0] op_a;
  logic [N:0] op_b;
  logic [N:0] sum;
  logic [N:0] carry;

  assign op_a   = {1'b0, star};
  assign op_b   = {1'b0, star & act[N-1:0]};
  assign sum    = op_a + op_b;
  assign carry  = sum ^ op_a ^ op_b;
  assign closed = act | carry;

endmodule

### src/gwm_cell.sv
`timescale 1ns / 1ps

// One pattern position: its pattern byte and its activity bit.
module gwm_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gwm_pkg::cell_ctrl_t ctrl,
  input  logic [LEN_W-1:0]   pat_len,
  input  logic               closed_self,  // own activity after closure
  input  logic               closed_prev,  // left neighbor after closure
  input  logic               adv_prev,     // left neighbor passes on this byte
  output logic               active,
  output logic               star,
  output logic               adv
);

  logic [7:0] pat_r;
  logic       act_r;
  logic       act_nxt;
  logic       in_use;

  assign in_use = LEN_W'(IDX) < pat_len;
  assign star   = in_use && (pat_r == gwm_pkg::SYM_ANY_RUN);
  // Hand activity to the right neighbor on a byte match
  assign adv    = in_use && (pat_r != gwm_pkg::SYM_ANY_RUN) &&
                  ((pat_r == gwm_pkg::SYM_ANY_ONE) || (pat_r == ctrl.sym));
  assign active = act_r;

  always_comb begin
    act_nxt = act_r;
    if (ctrl.restart) begin
      act_nxt = (IDX == 0);
    end else if (ctrl.step) begin
      act_nxt = (closed_self && star) || (closed_prev && adv_prev);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= (IDX == 0);
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && (pat_len == LEN_W'(IDX))) begin
      pat_r <= ctrl.sym;
    end
  end

endmodule

### src/glob_wildcard_matcher.sv
`timescale 1ns / 1ps

// Glob wildcard matcher.
// Input channel (in_*): one beat per item. in_tuser is the item kind:
// clear pattern, append pattern byte, name byte, end of name. in_tdata
// carries the byte for append and name beats and is ignored otherwise.
// Result channel (out_*): one beat per end-of-name beat, with the match
// verdict and the pattern overflow flag (matched is 0 whenever the
// pattern overflowed its PATTERN_LEN byte store).
// Throughput: one input beat per cycle, every kind, while in_tready is
// high. Each pattern position is a cell that updates in parallel; the
// star closure is one carry chain across the row.
// Latency: the verdict appears on out_* the cycle after the end-of-name
// beat is taken.
// Reset (rst_n low, synchronous): pattern empty, overflow flag clear,
// only position zero active, no result pending.
// Stall: the result sits in an output register; while it waits, the
// input keeps taking beats as long as out_tready is high or the register
// is empty. With a result held and out_tready low, in_tready drops.
module glob_wildcard_matcher #(
  parameter int PATTERN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic [1:0] in_tuser,   // [1:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);

  localparam int LEN_W = $clog2(PATTERN_LEN + 1);

  gwm_pkg::func_t      func;
  gwm_pkg::cell_ctrl_t ctrl;
  logic                in_acc;

  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    len_nxt;
  logic                ovf_r;
  logic                ovf_nxt;
  logic                fin_r;     // activity of the position past the end of the store
  logic                fin_nxt;
  logic                full;

  logic [PATTERN_LEN:0]   act;
  logic [PATTERN_LEN:0]   closed;
  logic [PATTERN_LEN-1:0] star;
  logic [PATTERN_LEN-1:0] adv;

  logic                out_vld_r;
  logic                out_match_r;
  logic                out_ovf_r;
  logic                hit;

  assign func      = gwm_pkg::func_t'(in_tuser);
  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (len_r == LEN_W'(PATTERN_LEN));

  assign ctrl.restart = in_acc && ((func == gwm_pkg::FUNC_CLEAR) ||
                                   (func == gwm_pkg::FUNC_END));
  assign ctrl.append  = in_acc && (func == gwm_pkg::FUNC_APPEND) && !full;
  assign ctrl.step    = in_acc && (func == gwm_pkg::FUNC_NAME);
  assign ctrl.sym     = in_tdata;

  // Row of position cells; each takes activity from its left neighbor
  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    logic c_prev;
    logic a_prev;
    if (i == 0) begin : g_first
      assign c_prev = 1'b0;
      assign a_prev = 1'b0;
    end else begin : g_rest
      assign c_prev = closed[i-1];
      assign a_prev = adv[i-1];
    end
    gwm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .pat_len     (len_r),
      .closed_self (closed[i]),
      .closed_prev (c_prev),
      .adv_prev    (a_prev),
      .active      (act[i]),
      .star        (star[i]),
      .adv         (adv[i])
    );
  end

  assign act[PATTERN_LEN] = fin_r;

  gwm_closure #(
    .N (PATTERN_LEN)
  ) u_closure (
    .act    (act),
    .star   (star),
    .closed (closed)
  );

  // Verdict: the position right after the last stored byte, post closure
  assign hit = closed[len_r] && !ovf_r;

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    fin_nxt = fin_r;
    if (in_acc && (func == gwm_pkg::FUNC_CLEAR)) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (in_acc && (func == gwm_pkg::FUNC_APPEND)) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
      end
    end
    if (ctrl.restart) begin
      fin_nxt = 1'b0;
    end else if (ctrl.step) begin
      fin_nxt = closed[PATTERN_LEN-1] && adv[PATTERN_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      fin_r <= fin_nxt;
    end
  end

  // Output register: load on end of name, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc && (func == gwm_pkg::FUNC_END)) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (func == gwm_pkg::FUNC_END)) begin
      out_match_r <= hit;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_match_r};

  // Overflow can only be flagged with the store full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow flag set with room in the pattern store");

  // Never report a match together with overflow
  a_no_match_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("match reported on an overflowed pattern");

  // An end-of-name beat always leaves a result pending
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == gwm_pkg::FUNC_END)) |=> out_tvalid)
    else $error("end of name produced no result");

  // Length never runs past the store
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PATTERN_LEN))
    else $error("pattern length beyond store");

endmodule

### tb/glob_wildcard_matcher_tb.sv
`timescale 1ns / 1ps

module glob_wildcard_matcher_tb;

  localparam int PAT_DEPTH   = 32;
  localparam int ITEM_TARGET = 1100;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int LIMIT_NS    = 10_000_000;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_X = 8'h78;

  typedef logic [7:0] sym_q_t[$];

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] symbol
  logic [1:0] in_tuser = 2'b00;   // [1:0] func
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] matched, [1] pattern_overflow, [7:2] zero

  // Pacing controls shared by the stimulus and the receiver
  bit steady = 1'b0;        // no gaps on either side
  bit hold_req = 1'b0;      // ask the receiver for one long hold-off
  bit mix_appends = 1'b0;   // drop pattern beats into names now and then
  int hold_left = 0;
  int stall_left = 0;

  int item_count = 0;
  int error_count = 0;

  // Bench copy of the matcher state
  logic [7:0]       pat_mem [PAT_DEPTH];
  int               pat_len = 0;
  logic [PAT_DEPTH:0] live_pos = (PAT_DEPTH + 1)'(1);
  logic             pat_ovf = 1'b0;
  verdict_t         verdict_q[$];

  glob_wildcard_matcher #(
    .PATTERN_LEN(PAT_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Let activity pass across every star, lowest position first
  function automatic logic [PAT_DEPTH:0] close_stars(logic [PAT_DEPTH:0] act);
    for (int i = 0; i < pat_len; i++) begin
      if (act[i] && pat_mem[i] == gwm_pkg::SYM_ANY_RUN) act[i+1] = 1'b1;
    end
    return act;
  endfunction

  // Advance the bench state by one accepted beat; queue a verdict on end of name
  function automatic void apply_item(gwm_pkg::func_t f, logic [7:0] s);
    logic [PAT_DEPTH:0] cur;
    logic [PAT_DEPTH:0] nxt;
    verdict_t v;
    case (f)
      gwm_pkg::FUNC_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        live_pos = (PAT_DEPTH + 1)'(1);
      end
      gwm_pkg::FUNC_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = s;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      gwm_pkg::FUNC_NAME: begin
        cur = close_stars(live_pos);
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (cur[i]) begin
            if (pat_mem[i] == gwm_pkg::SYM_ANY_RUN) nxt[i] = 1'b1;
            else if (pat_mem[i] == gwm_pkg::SYM_ANY_ONE || pat_mem[i] == s) nxt[i+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      default: begin
        cur = close_stars(live_pos);
        v.matched = cur[pat_len] && !pat_ovf;
        v.overflow = pat_ovf;
        verdict_q.push_back(v);
        live_pos = (PAT_DEPTH + 1)'(1);
      end
    endcase
  endfunction

  // Drive one beat at the falling edge, hold it until taken, then track it
  task automatic send_item(input gwm_pkg::func_t f, input logic [7:0] s);
    int gap;
    gap = steady ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_item(f, s);
    item_count++;
  endtask

  function automatic logic [7:0] pick_pat_sym();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return gwm_pkg::SYM_ANY_RUN;
    if (r < 45) return gwm_pkg::SYM_ANY_ONE;
    if (r < 90) return CH_A + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // Build a name that the pattern accepts
  function automatic sym_q_t expand_pattern(sym_q_t pat);
    sym_q_t name;
    foreach (pat[i]) begin
      if (pat[i] == gwm_pkg::SYM_ANY_RUN) begin
        repeat ($urandom_range(0, 3)) name.push_back(CH_A + 8'($urandom_range(0, 2)));
      end else if (pat[i] == gwm_pkg::SYM_ANY_ONE) begin
        name.push_back(8'($urandom_range(0, 255)));
      end else begin
        name.push_back(pat[i]);
      end
    end
    return name;
  endfunction

  task automatic load_pattern(input sym_q_t pat);
    send_item(gwm_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)));
    foreach (pat[i]) send_item(gwm_pkg::FUNC_APPEND, pat[i]);
  endtask

  task automatic send_name(input sym_q_t name);
    foreach (name[i]) begin
      if (mix_appends && $urandom_range(0, 39) == 0)
        send_item(gwm_pkg::FUNC_APPEND, pick_pat_sym());
      send_item(gwm_pkg::FUNC_NAME, name[i]);
    end
    send_item(gwm_pkg::FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // Check every result beat against the oldest queued verdict
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected, got tdata=%h", $time, out_tdata);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want.matched) begin
          $display("%0t: matched expected %0b got %0b", $time, want.matched, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[1] !== want.overflow) begin
          $display("%0t: pattern_overflow expected %0b got %0b",
                   $time, want.overflow, out_tdata[1]);
          error_count++;
        end
        if (out_tdata[7:2] !== 6'd0) begin
          $display("%0t: tdata pad expected 0 got %h", $time, out_tdata[7:2]);
          error_count++;
        end
      end
    end
  end

  // Extreme bytes, every kind, empty names, appends in the middle of a name
  task automatic test_directed();
    send_item(gwm_pkg::FUNC_END, 8'hFF);            // empty pattern, empty name
    send_item(gwm_pkg::FUNC_NAME, 8'h00);           // zero byte is an ordinary byte
    send_item(gwm_pkg::FUNC_END, 8'h00);
    send_item(gwm_pkg::FUNC_APPEND, gwm_pkg::SYM_ANY_RUN);
    send_item(gwm_pkg::FUNC_END, 8'h55);            // star alone takes the empty name
    send_item(gwm_pkg::FUNC_APPEND, gwm_pkg::SYM_ANY_RUN);
    send_item(gwm_pkg::FUNC_END, 8'hAA);
    send_item(gwm_pkg::FUNC_NAME, 8'h00);
    send_item(gwm_pkg::FUNC_NAME, 8'hFF);
    send_item(gwm_pkg::FUNC_END, 8'h00);
    send_item(gwm_pkg::FUNC_CLEAR, 8'hFF);
    send_item(gwm_pkg::FUNC_APPEND, CH_A);
    send_item(gwm_pkg::FUNC_APPEND, gwm_pkg::SYM_ANY_ONE);
    send_item(gwm_pkg::FUNC_NAME, CH_A);
    send_item(gwm_pkg::FUNC_APPEND, 8'hFF);         // pattern grows under a live name
    send_item(gwm_pkg::FUNC_NAME, CH_X);
    send_item(gwm_pkg::FUNC_NAME, 8'hFF);
    send_item(gwm_pkg::FUNC_END, 8'hFF);
    send_item(gwm_pkg::FUNC_NAME, CH_A);
    send_item(gwm_pkg::FUNC_NAME, 8'h00);
    send_item(gwm_pkg::FUNC_END, 8'h00);            // name one byte short
    send_item(gwm_pkg::FUNC_CLEAR, 8'h00);
    send_item(gwm_pkg::FUNC_END, 8'h00);
  endtask

  // Fill the store exactly, then push past it and clear again
  task automatic test_overflow();
    sym_q_t pat;
    sym_q_t name;
    repeat (PAT_DEPTH) pat.push_back(pick_pat_sym());
    load_pattern(pat);
    name = expand_pattern(pat);
    send_name(name);
    send_item(gwm_pkg::FUNC_APPEND, 8'hFF);
    send_name(name);
    send_item(gwm_pkg::FUNC_APPEND, 8'h00);
    send_item(gwm_pkg::FUNC_END, 8'h00);
    send_item(gwm_pkg::FUNC_CLEAR, 8'h00);
    send_item(gwm_pkg::FUNC_END, 8'hFF);
  endtask

  // Hold the receiver off while the sender keeps offering back to back
  task automatic test_backpressure();
    sym_q_t pat;
    sym_q_t name;
    steady = 1'b1;
    hold_req = 1'b1;
    pat = '{CH_A, gwm_pkg::SYM_ANY_RUN, gwm_pkg::SYM_ANY_ONE};
    load_pattern(pat);
    repeat (8) begin
      name = expand_pattern(pat);
      if ($urandom_range(0, 2) == 0) name.push_back(8'($urandom_range(0, 255)));
      send_name(name);
    end
    steady = 1'b0;
  endtask

  // Mostly well-formed pattern and name runs, some noise
  task automatic test_random();
    sym_q_t pat;
    sym_q_t name;
    int r;
    int n_pat;
    mix_appends = 1'b1;
    while (item_count < ITEM_TARGET) begin
      steady = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 6))
          send_item(gwm_pkg::func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 80) n_pat = $urandom_range(0, 8);
      else if (r < 96) n_pat = $urandom_range(9, PAT_DEPTH - 1);
      else n_pat = $urandom_range(PAT_DEPTH, PAT_DEPTH + 3);
      pat.delete();
      repeat (n_pat) pat.push_back(pick_pat_sym());
      load_pattern(pat);
      repeat ($urandom_range(1, 4)) begin
        name = expand_pattern(pat);
        r = $urandom_range(0, 8);
        // Break about a third of the names: flip a byte, drop one or add one
        if (r == 0 && name.size() > 0)
          name[$urandom_range(0, name.size() - 1)] = 8'($urandom_range(0, 255));
        else if (r == 1 && name.size() > 0)
          void'(name.pop_back());
        else if (r == 2)
          name.push_back(CH_A + 8'($urandom_range(0, 2)));
        send_name(name);
      end
    end
    steady = 1'b0;
    mix_appends = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_overflow();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
      error_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
src/gwm_pkg.sv
src/gwm_closure.sv
src/gwm_cell.sv
src/glob_wildcard_matcher.sv
tb/glob_wildcard_matcher_tb.sv
